>>> design/tbc_pkg.sv
package tbc_pkg;

   localparam int DataWidth   = 8;
   localparam int AddrWidth   = 8;
   localparam int MemDepth    = 1 << AddrWidth;
   localparam int NumRegs     = 5;
   localparam int RegIdxWidth = $clog2(NumRegs);

   localparam logic [DataWidth-1:0] PcRegIndex = DataWidth'(NumRegs);
   localparam logic [AddrWidth-1:0] HaltPc     = '1;

   localparam logic ReqWrite = 1'b0;
   localparam logic ReqExec  = 1'b1;

   localparam logic [DataWidth-1:0] OpNop = 8'h00;
   localparam logic [DataWidth-1:0] OpAdd = 8'h01;
   localparam logic [DataWidth-1:0] OpSub = 8'h02;
   localparam logic [DataWidth-1:0] OpJmp = 8'h03;
   localparam logic [DataWidth-1:0] OpBlt = 8'h04;
   localparam logic [DataWidth-1:0] OpLd  = 8'h05;
   localparam logic [DataWidth-1:0] OpSt  = 8'h06;

   typedef logic [NumRegs-1:0][DataWidth-1:0] regfile_type;

   // one access of the single memory port
   typedef struct packed {
      logic                 en;
      logic                 we;
      logic [AddrWidth-1:0] addr;
      logic [DataWidth-1:0] wdata;
   } mem_cmd_type;

   // architectural state handed to the response register
   typedef struct packed {
      logic [AddrWidth-1:0] pc;
      regfile_type          regs;
      logic                 err;
   } arch_type;

endpackage

>>> design/tbc_mem.sv
module tbc_mem (
   input  logic                            clock,
   input  logic                            reset,
   input  tbc_pkg::mem_cmd_type            cmd,
   output logic [tbc_pkg::DataWidth-1:0]   rdata
);
   import tbc_pkg::*;

   logic [DataWidth-1:0] mem_ff [MemDepth];
   logic [MemDepth-1:0]  valid_ff;
   logic [DataWidth-1:0] rdata_ff;

   // unwritten entries read as zero, so reset needs no clearing pass
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.en && cmd.we) begin
         valid_ff[cmd.addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.en && cmd.we) begin
         mem_ff[cmd.addr] <= cmd.wdata;
      end
      if (cmd.en && !cmd.we) begin
         rdata_ff <= valid_ff[cmd.addr] ? mem_ff[cmd.addr] : '0;
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> design/tbc_exec.sv
module tbc_exec (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_type,
   input  logic [tbc_pkg::AddrWidth-1:0]   req_mem_addr,
   input  logic [tbc_pkg::DataWidth-1:0]   req_mem_data,
   input  logic                            out_free,
   output logic                            done,
   output tbc_pkg::arch_type               arch,
   output tbc_pkg::mem_cmd_type            mem_cmd,
   input  logic [tbc_pkg::DataWidth-1:0]   mem_rdata
);
   import tbc_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_F1, S_F2, S_F3, S_F4, S_EXEC, S_LOAD, S_DONE
   } state_type;

   state_type            state_ff;
   logic [AddrWidth-1:0] pc_ff;
   regfile_type          regs_ff;
   logic                 err_ff;
   logic [DataWidth-1:0] op_ff;
   logic [DataWidth-1:0] b0_ff;
   logic [DataWidth-1:0] b1_ff;
   logic [DataWidth-1:0] b2_ff;

   logic                 accept;
   logic [DataWidth-1:0] ra;
   logic [DataWidth-1:0] rb;
   logic [DataWidth-1:0] sum;
   logic [DataWidth-1:0] diff;

   function automatic logic [DataWidth-1:0] read_reg(input logic [DataWidth-1:0] idx,
                                                     input regfile_type r,
                                                     input logic [AddrWidth-1:0] pc);
      logic [DataWidth-1:0] val;
      val = '0;
      if (idx < DataWidth'(NumRegs)) begin
         val = r[idx[RegIdxWidth-1:0]];
      end else if (idx == PcRegIndex) begin
         val = DataWidth'(pc);
      end
      return val;
   endfunction

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign done      = (state_ff == S_DONE) && out_free;
   assign ra        = read_reg(b0_ff, regs_ff, pc_ff);
   assign rb        = read_reg(b1_ff, regs_ff, pc_ff);
   assign sum       = ra + rb;
   assign diff      = ra - rb;

   assign arch.pc   = pc_ff;
   assign arch.regs = regs_ff;
   assign arch.err  = err_ff;

   always_comb begin
      mem_cmd = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept && req_type == ReqWrite) begin
               mem_cmd.en    = 1'b1;
               mem_cmd.we    = 1'b1;
               mem_cmd.addr  = req_mem_addr;
               mem_cmd.wdata = req_mem_data;
            end else if (accept && pc_ff != HaltPc) begin
               mem_cmd.en   = 1'b1;
               mem_cmd.addr = pc_ff;
            end
         end
         S_F1: begin
            mem_cmd.en   = 1'b1;
            mem_cmd.addr = pc_ff + AddrWidth'(1);
         end
         S_F2: begin
            mem_cmd.en   = 1'b1;
            mem_cmd.addr = pc_ff + AddrWidth'(2);
         end
         S_F3: begin
            mem_cmd.en   = 1'b1;
            mem_cmd.addr = pc_ff + AddrWidth'(3);
         end
         S_EXEC: begin
            if (op_ff == OpLd) begin
               mem_cmd.en   = 1'b1;
               mem_cmd.addr = AddrWidth'(b1_ff);
            end else if (op_ff == OpSt) begin
               mem_cmd.en    = 1'b1;
               mem_cmd.we    = 1'b1;
               mem_cmd.addr  = AddrWidth'(b1_ff);
               mem_cmd.wdata = ra;
            end
         end
         default: begin
            mem_cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pc_ff    <= '0;
         regs_ff  <= '0;
         err_ff   <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  if (req_type == ReqExec && pc_ff != HaltPc) begin
                     state_ff <= S_F1;
                  end else begin
                     state_ff <= S_DONE;
                  end
               end
            end
            S_F1: begin
               op_ff    <= mem_rdata;
               state_ff <= S_F2;
            end
            S_F2: begin
               b0_ff    <= mem_rdata;
               state_ff <= S_F3;
            end
            S_F3: begin
               b1_ff    <= mem_rdata;
               state_ff <= S_F4;
            end
            S_F4: begin
               b2_ff    <= mem_rdata;
               state_ff <= S_EXEC;
            end
            S_EXEC: begin
               state_ff <= S_DONE;
               case (op_ff)
                  OpNop: begin
                     pc_ff <= pc_ff + AddrWidth'(1);
                  end
                  OpAdd: begin
                     if (b2_ff < DataWidth'(NumRegs)) begin
                        regs_ff[b2_ff[RegIdxWidth-1:0]] <= sum;
                     end
                     pc_ff <= pc_ff + AddrWidth'(4);
                  end
                  OpSub: begin
                     if (b2_ff < DataWidth'(NumRegs)) begin
                        regs_ff[b2_ff[RegIdxWidth-1:0]] <= diff;
                     end
                     pc_ff <= pc_ff + AddrWidth'(4);
                  end
                  OpJmp: begin
                     pc_ff <= AddrWidth'(b0_ff);
                  end
                  OpBlt: begin
                     pc_ff <= (ra < rb) ? AddrWidth'(b2_ff) : pc_ff + AddrWidth'(4);
                  end
                  OpLd: begin
                     state_ff <= S_LOAD;
                  end
                  OpSt: begin
                     pc_ff <= pc_ff + AddrWidth'(3);
                  end
                  default: begin
                     err_ff <= 1'b1;
                     pc_ff  <= HaltPc;
                  end
               endcase
            end
            S_LOAD: begin
               if (b0_ff < DataWidth'(NumRegs)) begin
                  regs_ff[b0_ff[RegIdxWidth-1:0]] <= mem_rdata;
               end
               pc_ff    <= pc_ff + AddrWidth'(3);
               state_ff <= S_DONE;
            end
            S_DONE: begin
               if (out_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

>>> design/tiny_byte_cpu_step.sv
// Tiny 8-bit processor, one request at a time.
// Request channel (req_valid/req_stall): req_type low writes req_mem_data
// to memory at req_mem_addr (program load); req_type high executes the
// instruction at the program counter. Address and data are ignored for
// execute requests.
// Response channel (rsp_valid/rsp_stall): one response per request with
// the program counter, registers A..E, halted and the sticky illegal-opcode
// flag as they stand after that request.
// From acceptance to response valid, a memory write or an execute while
// halted goes straight to S_DONE; an instruction passes S_F1..S_F4 and
// S_EXEC, and a load adds S_LOAD. A new request is taken in the cycle after
// the response is registered. The sequence is set by the single memory port:
// four instruction-byte reads in a row, then the data access of a load or store.
// Reset clears the registers, program counter and error flag and marks all
// memory bytes unwritten, so they read as zero; no clearing pass is needed.
// A stalled response stays in the output register while the next request
// is accepted and executed; that result then waits until the slot frees.
module tiny_byte_cpu_step (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_type,
   input  logic [tbc_pkg::AddrWidth-1:0]   req_mem_addr,
   input  logic [tbc_pkg::DataWidth-1:0]   req_mem_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [tbc_pkg::AddrWidth-1:0]   rsp_pc,
   output logic [tbc_pkg::DataWidth-1:0]   rsp_reg_a,
   output logic [tbc_pkg::DataWidth-1:0]   rsp_reg_b,
   output logic [tbc_pkg::DataWidth-1:0]   rsp_reg_c,
   output logic [tbc_pkg::DataWidth-1:0]   rsp_reg_d,
   output logic [tbc_pkg::DataWidth-1:0]   rsp_reg_e,
   output logic                            rsp_halted,
   output logic                            rsp_illegal_opcode
);
   import tbc_pkg::*;

   mem_cmd_type          mem_cmd;
   logic [DataWidth-1:0] mem_rdata;
   arch_type             arch;
   logic                 req_ready;
   logic                 done;
   logic                 out_free;

   logic                 rsp_valid_ff;
   arch_type             rsp_ff;

   tbc_mem u_mem (
      .clock (clock),
      .reset (reset),
      .cmd   (mem_cmd),
      .rdata (mem_rdata)
   );

   tbc_exec u_exec (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_type     (req_type),
      .req_mem_addr (req_mem_addr),
      .req_mem_data (req_mem_data),
      .out_free     (out_free),
      .done         (done),
      .arch         (arch),
      .mem_cmd      (mem_cmd),
      .mem_rdata    (mem_rdata)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (done) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         rsp_ff <= arch;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_pc             = rsp_ff.pc;
   assign rsp_reg_a          = rsp_ff.regs[0];
   assign rsp_reg_b          = rsp_ff.regs[1];
   assign rsp_reg_c          = rsp_ff.regs[2];
   assign rsp_reg_d          = rsp_ff.regs[3];
   assign rsp_reg_e          = rsp_ff.regs[4];
   assign rsp_halted         = (rsp_ff.pc == HaltPc);
   assign rsp_illegal_opcode = rsp_ff.err;

   a_err_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_illegal_opcode |=> rsp_illegal_opcode)
      else $error("illegal-opcode flag cleared without reset");

   a_err_halts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_illegal_opcode |-> rsp_halted)
      else $error("error reported while not halted");

   a_rsp_drains: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !done |=> !rsp_valid)
      else $error("response repeated after handshake");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted back to back while busy");

endmodule

>>> verif/tb_tiny_byte_cpu_step.sv
module tb_tiny_byte_cpu_step;
   import tbc_pkg::*;

   typedef struct packed {
      logic [7:0] pc;
      logic [7:0] ra;
      logic [7:0] rb;
      logic [7:0] rc;
      logic [7:0] rd;
      logic [7:0] re;
      logic       halted;
      logic       err;
   } arch_view_type;

   typedef enum int {
      StallNone,
      StallHalf,
      StallHeavy,
      StallBeat
   } stall_mode_type;

   localparam logic [7:0] LegalOps [7] = '{OpNop, OpAdd, OpSub, OpJmp, OpBlt, OpLd, OpSt};

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic       req_type = ReqWrite;
   logic [7:0] req_mem_addr = '0;
   logic [7:0] req_mem_data = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_pc;
   logic [7:0] rsp_reg_a;
   logic [7:0] rsp_reg_b;
   logic [7:0] rsp_reg_c;
   logic [7:0] rsp_reg_d;
   logic [7:0] rsp_reg_e;
   logic       rsp_halted;
   logic       rsp_illegal_opcode;

   // predicted architectural state
   logic [7:0] mem_img [256];
   logic [7:0] reg_img [NumRegs];
   logic [7:0] pc_img = '0;
   logic       err_img = 1'b0;

   arch_view_type arch_after_q [$];

   int n_sent = 0;
   int n_exec = 0;
   int n_checked = 0;
   int n_err = 0;
   int burst_left = 0;

   stall_mode_type stall_mode = StallNone;
   int             stall_left = 0;
   int             cyc = 0;

   tiny_byte_cpu_step dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_type           (req_type),
      .req_mem_addr       (req_mem_addr),
      .req_mem_data       (req_mem_data),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_pc             (rsp_pc),
      .rsp_reg_a          (rsp_reg_a),
      .rsp_reg_b          (rsp_reg_b),
      .rsp_reg_c          (rsp_reg_c),
      .rsp_reg_d          (rsp_reg_d),
      .rsp_reg_e          (rsp_reg_e),
      .rsp_halted         (rsp_halted),
      .rsp_illegal_opcode (rsp_illegal_opcode)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      foreach (mem_img[i]) mem_img[i] = '0;
      foreach (reg_img[i]) reg_img[i] = '0;
   end

   // ---------------- predictor ----------------

   function automatic logic [7:0] reg_rd(logic [7:0] idx);
      if (idx < NumRegs) return reg_img[idx];
      if (idx == PcRegIndex) return pc_img;
      return '0;
   endfunction

   // returns the next pc; state only changes when apply is set
   function automatic logic [7:0] cpu_step(logic [7:0] op, logic [7:0] b0, logic [7:0] b1,
                                           logic [7:0] b2, bit apply);
      logic [7:0] nxt;
      logic [7:0] val;
      logic [7:0] widx;
      logic [7:0] seq3;
      logic [7:0] seq4;
      bit         wr;
      wr = 1'b0;
      widx = '0;
      val = '0;
      seq3 = pc_img + 8'd3;
      seq4 = pc_img + 8'd4;
      case (op)
         OpNop: nxt = pc_img + 8'd1;
         OpAdd: begin
            val = reg_rd(b0) + reg_rd(b1);
            widx = b2;
            wr = 1'b1;
            nxt = seq4;
         end
         OpSub: begin
            val = reg_rd(b0) - reg_rd(b1);
            widx = b2;
            wr = 1'b1;
            nxt = seq4;
         end
         OpJmp: nxt = b0;
         OpBlt: nxt = (reg_rd(b0) < reg_rd(b1)) ? b2 : seq4;
         OpLd: begin
            val = mem_img[b1];
            widx = b0;
            wr = 1'b1;
            nxt = seq3;
         end
         OpSt: begin
            if (apply) mem_img[b1] = reg_rd(b0);
            nxt = seq3;
         end
         default: begin
            if (apply) err_img = 1'b1;
            nxt = HaltPc;
         end
      endcase
      if (apply) begin
         if (wr && widx < NumRegs) reg_img[widx] = val;
         pc_img = nxt;
      end
      return nxt;
   endfunction

   function automatic logic [7:0] exec_here(bit apply);
      logic [7:0] p1;
      logic [7:0] p2;
      logic [7:0] p3;
      p1 = pc_img + 8'd1;
      p2 = pc_img + 8'd2;
      p3 = pc_img + 8'd3;
      return cpu_step(mem_img[pc_img], mem_img[p1], mem_img[p2], mem_img[p3], apply);
   endfunction

   function automatic void note_accepted(logic typ, logic [7:0] a, logic [7:0] d);
      arch_view_type v;
      if (typ == ReqWrite) begin
         mem_img[a] = d;
      end else begin
         n_exec++;
         if (pc_img != HaltPc) void'(exec_here(1'b1));
      end
      v.pc = pc_img;
      v.ra = reg_img[0];
      v.rb = reg_img[1];
      v.rc = reg_img[2];
      v.rd = reg_img[3];
      v.re = reg_img[4];
      v.halted = (pc_img == HaltPc);
      v.err = err_img;
      arch_after_q.push_back(v);
   endfunction

   // ---------------- request side ----------------

   task automatic send_req(logic typ, logic [7:0] a, logic [7:0] d);
      int gap;
      req_valid <= 1'b1;
      req_type <= typ;
      req_mem_addr <= a;
      req_mem_data <= d;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      note_accepted(typ, a, d);
      n_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
         gap = $urandom_range(1, 9);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // program load writes already holding the byte are skipped
   task automatic put_byte(logic [7:0] a, logic [7:0] d);
      if (mem_img[a] !== d) send_req(ReqWrite, a, d);
   endtask

   task automatic exec_instr();
      send_req(ReqExec, 8'($urandom), 8'($urandom));
   endtask

   task automatic place_instr(logic [7:0] op, logic [7:0] b0, logic [7:0] b1, logic [7:0] b2);
      logic [7:0] at;
      int         len;
      at = pc_img;
      case (op)
         OpNop:               len = 1;
         OpJmp:               len = 2;
         OpLd, OpSt:          len = 3;
         OpAdd, OpSub, OpBlt: len = 4;
         default:             len = 1;
      endcase
      put_byte(at, op);
      if (len > 1) put_byte(at + 8'd1, b0);
      if (len > 2) put_byte(at + 8'd2, b1);
      if (len > 3) put_byte(at + 8'd3, b2);
   endtask

   task automatic run_instr(logic [7:0] op, logic [7:0] b0, logic [7:0] b1, logic [7:0] b2);
      place_instr(op, b0, b1, b2);
      exec_instr();
   endtask

   function automatic logic [7:0] rand_reg_idx();
      int k;
      k = $urandom_range(0, 15);
      if (k < 10) return 8'($urandom_range(0, NumRegs - 1));
      if (k < 12) return PcRegIndex;
      if (k < 14) return 8'($urandom_range(6, 7));
      return 8'($urandom);
   endfunction

   // ---------------- tests ----------------

   task automatic test_reset_state();
      send_req(ReqWrite, 8'hFF, 8'hFF);
      send_req(ReqWrite, 8'h00, 8'h00);
      exec_instr();  // cleared memory decodes as NOP
   endtask

   task automatic test_arith_wrap();
      run_instr(OpLd, 8'd0, 8'hFF, 8'd0);
      run_instr(OpAdd, 8'd0, 8'd0, 8'd1);  // carry out dropped
      run_instr(OpSub, 8'd2, 8'd0, 8'd3);  // borrow wraps
   endtask

   task automatic test_reg_index_edges();
      run_instr(OpAdd, PcRegIndex, 8'd6, 8'd4);  // pc read, zero read
      run_instr(OpSub, 8'd0, 8'hFF, PcRegIndex);  // write to pc slot dropped
      run_instr(OpLd, 8'd7, 8'hFF, 8'd0);         // write above pc slot dropped
   endtask

   task automatic test_branch_wrap();
      run_instr(OpBlt, 8'd0, 8'd1, 8'h40);   // not taken
      run_instr(OpBlt, 8'd1, 8'd0, 8'hFD);   // taken
      run_instr(OpBlt, 8'd2, 8'd2, 8'h77);   // operands wrap past 0xFF, equal not taken
      run_instr(OpJmp, 8'h30, 8'd0, 8'd0);
   endtask

   task automatic test_load_store();
      run_instr(OpSt, PcRegIndex, 8'h90, 8'd0);
      run_instr(OpSt, 8'd0, 8'h91, 8'd0);
      run_instr(OpSt, 8'd6, 8'h91, 8'd0);
      run_instr(OpLd, 8'd4, 8'h90, 8'd0);
      run_instr(OpLd, 8'd1, 8'h91, 8'd0);
   endtask

   // mostly well-formed instructions at the pc, never allowed to halt
   task automatic test_random_programs(int n_items);
      int         stop_at;
      int         r;
      logic [7:0] op;
      logic [7:0] b0;
      logic [7:0] b1;
      logic [7:0] b2;
      stop_at = n_sent + n_items;
      while (n_sent < stop_at) begin
         r = $urandom_range(0, 99);
         if (r < 80) begin
            op = LegalOps[$urandom_range(0, 6)];
            b0 = rand_reg_idx();
            b1 = rand_reg_idx();
            b2 = rand_reg_idx();
            if (op == OpJmp) b0 = 8'($urandom);
            if (op == OpBlt) b2 = 8'($urandom);
            if (op == OpLd || op == OpSt) b1 = 8'($urandom);
            if (cpu_step(op, b0, b1, b2, 1'b0) == HaltPc) begin
               op = OpJmp;
               b0 = 8'($urandom_range(0, 254));
            end
            if (op == OpLd && $urandom_range(0, 1) == 1) put_byte(b1, 8'($urandom));
            run_instr(op, b0, b1, b2);
         end else if (r < 92) begin
            repeat ($urandom_range(1, 3)) send_req(ReqWrite, 8'($urandom), 8'($urandom));
         end else if (exec_here(1'b0) != HaltPc) begin
            exec_instr();  // whatever memory holds at the pc
         end else begin
            send_req(ReqWrite, pc_img, OpNop);
         end
      end
   endtask

   // halts for good, so it runs last
   task automatic test_illegal_opcode();
      run_instr(8'($urandom_range(7, 255)), 8'd0, 8'd0, 8'd0);
      repeat (24) begin
         if ($urandom_range(0, 1) == 1) exec_instr();
         else send_req(ReqWrite, 8'($urandom), 8'($urandom));
      end
      exec_instr();
   endtask

   // ---------------- response side ----------------

   always @(posedge clock) begin
      cyc++;
      if (stall_left == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 3));
         stall_left = $urandom_range(20, 200);
      end else begin
         stall_left--;
      end
      case (stall_mode)
         StallNone:  rsp_stall <= 1'b0;
         StallHalf:  rsp_stall <= ($urandom_range(0, 1) == 1);
         StallHeavy: rsp_stall <= ($urandom_range(0, 4) != 0);
         default:    rsp_stall <= ((cyc % 7) < 3);
      endcase
   end

   function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0h got %0h", $time, name, want, got);
         n_err++;
      end
   endfunction

   always @(posedge clock) begin : rsp_check
      arch_view_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         if (arch_after_q.size() == 0) begin
            $display("%0t: response with none expected, expected nothing got pc %0h",
                     $time, rsp_pc);
            n_err++;
         end else begin
            want = arch_after_q.pop_front();
            check_field("pc", want.pc, rsp_pc);
            check_field("reg_a", want.ra, rsp_reg_a);
            check_field("reg_b", want.rb, rsp_reg_b);
            check_field("reg_c", want.rc, rsp_reg_c);
            check_field("reg_d", want.rd, rsp_reg_d);
            check_field("reg_e", want.re, rsp_reg_e);
            check_field("halted", 8'(want.halted), 8'(rsp_halted));
            check_field("illegal_opcode", 8'(want.err), 8'(rsp_illegal_opcode));
            n_checked++;
         end
      end
   end

   // ---------------- sequence ----------------

   initial begin
      int waited;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_state();
      test_arith_wrap();
      test_reg_index_edges();
      test_branch_wrap();
      test_load_store();
      test_random_programs(1850);
      test_illegal_opcode();
      req_valid <= 1'b0;
      waited = 0;
      while (arch_after_q.size() != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      if (arch_after_q.size() != 0) begin
         $display("%0t: %0d responses never arrived", $time, arch_after_q.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         repeat (20) @(posedge clock);
         $display("covered %0d requests (%0d executes), %0d responses compared, %0d mismatches",
                  n_sent, n_exec, n_checked, n_err);
         $display("ended halted with pc %0h and error flag %0b", pc_img, err_img);
         if (n_err == 0) begin
            $display("SCOREBOARD CLEAN");
         end else begin
            $display("SCOREBOARD MISMATCH");
         end
         $finish;
      end
   end

   initial begin
      #3000000;
      $display("%0t: run did not finish in time", $time);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

>>> sim.f
design/tbc_pkg.sv
design/tbc_mem.sv
design/tbc_exec.sv
design/tiny_byte_cpu_step.sv
verif/tb_tiny_byte_cpu_step.sv
